// ----- hdl/ght_pkg.sv -----
package ght_pkg;

    localparam int SLOTS_DEF        = 256;
    localparam int VERSION_BITS_DEF = 16;

    typedef enum logic [1:0] {
        OP_CREATE   = 2'd0,
        OP_DESTROY  = 2'd1,
        OP_LOOKUP   = 2'd2,
        OP_REPARENT = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TGT_RD,
        ST_TGT_CHK,
        ST_SCAN,
        ST_RESP
    } state_t;

    // Which entry write the datapath performs this cycle.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_REUSE,
        WR_APPEND,
        WR_REPARENT,
        WR_KILL,
        WR_CHILD
    } wr_sel_t;

    // Which result the datapath captures into its pending result register.
    typedef enum logic [2:0] {
        RES_FAIL_HANDLE,
        RES_FAIL_FULL,
        RES_REUSE,
        RES_APPEND,
        RES_LOOKUP,
        RES_REPARENT,
        RES_DESTROY
    } res_sel_t;

    typedef struct packed {
        logic     in_load;
        logic     tgt_rd;
        logic     scan_en;
        wr_sel_t  wr_sel;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    tgt_ok;
        logic    scan_hit;
        logic    scan_done;
        logic    full;
        logic    out_free;
    } status_t;

endpackage

// ----- hdl/ght_ram.sv -----
module ght_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/ght_ctrl.sv -----
module ght_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  ght_pkg::opcode_t  s_opcode,
    output logic              s_tready,
    input  ght_pkg::status_t  status,
    output ght_pkg::cmd_t     cmd
);

    import ght_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_opcode == OP_CREATE) ? ST_SCAN : ST_TGT_RD;
                end
            end
            ST_TGT_RD: begin
                state_next = ST_TGT_CHK;
            end
            ST_TGT_CHK: begin
                state_next = (status.tgt_ok && status.op == OP_DESTROY) ? ST_SCAN : ST_RESP;
            end
            ST_SCAN: begin
                if (status.op == OP_CREATE) begin
                    if (status.scan_hit || status.scan_done) begin
                        state_next = ST_RESP;
                    end
                end else if (status.scan_done) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        cmd.in_load  = 1'b0;
        cmd.tgt_rd   = 1'b0;
        cmd.scan_en  = 1'b0;
        cmd.wr_sel   = WR_NONE;
        cmd.res_load = 1'b0;
        cmd.res_sel  = RES_FAIL_HANDLE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.in_load = s_tvalid;
            end
            ST_TGT_RD: begin
                cmd.tgt_rd = 1'b1;
            end
            ST_TGT_CHK: begin
                cmd.res_load = 1'b1;
                if (!status.tgt_ok) begin
                    cmd.res_sel = RES_FAIL_HANDLE;
                end else begin
                    unique case (status.op)
                        OP_LOOKUP: begin
                            cmd.res_sel = RES_LOOKUP;
                        end
                        OP_REPARENT: begin
                            cmd.wr_sel  = WR_REPARENT;
                            cmd.res_sel = RES_REPARENT;
                        end
                        OP_DESTROY: begin
                            cmd.wr_sel  = WR_KILL;
                            cmd.res_sel = RES_DESTROY;
                        end
                        OP_CREATE: begin
                            cmd.res_sel = RES_FAIL_FULL;
                        end
                        default: cmd.res_sel = RES_FAIL_HANDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (status.op == OP_CREATE) begin
                    if (status.scan_hit) begin
                        cmd.wr_sel   = WR_REUSE;
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_REUSE;
                    end else if (status.scan_done) begin
                        cmd.res_load = 1'b1;
                        if (status.full) begin
                            cmd.res_sel = RES_FAIL_FULL;
                        end else begin
                            cmd.wr_sel  = WR_APPEND;
                            cmd.res_sel = RES_APPEND;
                        end
                    end
                end else if (status.scan_hit) begin
                    cmd.wr_sel = WR_CHILD;
                end
            end
            ST_RESP: begin
                cmd.out_load = status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/ght_dp.sv -----
module ght_dp #(
    parameter int SLOTS        = ght_pkg::SLOTS_DEF,
    parameter int VERSION_BITS = ght_pkg::VERSION_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ght_pkg::cmd_t             cmd,
    output ght_pkg::status_t          status,
    input  ght_pkg::opcode_t          in_opcode,
    input  logic [$clog2(SLOTS)-1:0]  in_slot_index,
    input  logic [VERSION_BITS-1:0]   in_slot_version,
    input  logic [$clog2(SLOTS)-1:0]  in_parent_index,
    input  logic [VERSION_BITS-1:0]   in_parent_version,
    input  logic                      in_parent_none,
    input  logic                      m_tready,
    output logic                      m_tvalid,
    output logic                      out_success,
    output logic [$clog2(SLOTS)-1:0]  out_index,
    output logic [VERSION_BITS-1:0]   out_version,
    output logic [$clog2(SLOTS)-1:0]  out_parent_index,
    output logic [VERSION_BITS-1:0]   out_parent_version,
    output logic                      out_parent_none
);

    import ght_pkg::*;

    localparam int IDX_W  = $clog2(SLOTS);
    localparam int VER_W  = VERSION_BITS;
    localparam int CNT_W  = IDX_W + 1;
    localparam int LINK_W = 1 + IDX_W + VER_W;
    localparam int ENT_W  = 1 + VER_W + LINK_W;
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    // Latched request; the new parent is kept zeroed when it is "no parent".
    opcode_t            op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [VER_W-1:0]   ver_reg;
    logic [LINK_W-1:0]  np_reg;

    logic [CNT_W-1:0]   used_reg, used_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]   rd_addr_reg, rd_addr_next;

    logic               res_ok_reg, res_ok_next;
    logic [IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic [VER_W-1:0]   res_ver_reg, res_ver_next;
    logic [LINK_W-1:0]  res_link_reg, res_link_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_ok_reg;
    logic [IDX_W-1:0]   m_idx_reg;
    logic [VER_W-1:0]   m_ver_reg;
    logic [LINK_W-1:0]  m_link_reg;

    logic [IDX_W-1:0]   ram_raddr;
    logic [ENT_W-1:0]   ram_rdata;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENT_W-1:0]   ram_wdata;

    logic               r_live;
    logic [VER_W-1:0]   r_ver;
    logic [VER_W-1:0]   r_ver_inc;
    logic [LINK_W-1:0]  r_link;
    logic               issue;
    logic               np_self;
    logic               gp_self;
    logic               child;

    ght_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Entry layout from the top: live, version, parent {none, index, version}.
    assign r_live    = ram_rdata[ENT_W-1];
    assign r_ver     = ram_rdata[ENT_W-2 -: VER_W];
    assign r_link    = ram_rdata[LINK_W-1:0];
    assign r_ver_inc = r_ver + VER_W'(1);

    assign issue     = (cnt_reg < used_reg);
    assign ram_raddr = cmd.tgt_rd ? idx_reg : cnt_reg[IDX_W-1:0];

    assign np_self = !np_reg[LINK_W-1] && (np_reg[LINK_W-2 -: IDX_W] == idx_reg)
                     && (np_reg[VER_W-1:0] == ver_reg);
    // The destroyed entity's parent must not become a child's own parent.
    assign gp_self = !res_link_reg[LINK_W-1] && (res_link_reg[LINK_W-2 -: IDX_W] == rd_addr_reg)
                     && (res_link_reg[VER_W-1:0] == r_ver);
    assign child   = r_live && !r_link[LINK_W-1] && (r_link[LINK_W-2 -: IDX_W] == idx_reg)
                     && (r_link[VER_W-1:0] == ver_reg) && !gp_self;

    always_comb begin
        status.op        = op_reg;
        status.tgt_ok    = ({1'b0, idx_reg} < used_reg) && r_live && (r_ver == ver_reg);
        status.scan_hit  = rd_vld_reg && ((op_reg == OP_CREATE) ? !r_live : child);
        status.scan_done = !issue && !rd_vld_reg;
        status.full      = (used_reg == SLOTS_CNT);
        status.out_free  = !m_valid_reg || m_tready;
    end

    always_comb begin
        cnt_next     = cnt_reg;
        rd_vld_next  = rd_vld_reg;
        rd_addr_next = rd_addr_reg;
        if (cmd.in_load) begin
            cnt_next    = '0;
            rd_vld_next = 1'b0;
        end else if (cmd.scan_en) begin
            rd_vld_next  = issue;
            rd_addr_next = cnt_reg[IDX_W-1:0];
            if (issue) begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {1'b1, r_ver, np_reg};
        used_next = used_reg;
        unique case (cmd.wr_sel)
            WR_NONE: begin
                ram_we = 1'b0;
            end
            WR_REUSE: begin
                ram_we    = 1'b1;
                ram_waddr = rd_addr_reg;
                ram_wdata = {1'b1, r_ver_inc, np_reg};
            end
            WR_APPEND: begin
                ram_we    = 1'b1;
                ram_waddr = used_reg[IDX_W-1:0];
                ram_wdata = {1'b1, {VER_W{1'b0}}, np_reg};
                used_next = used_reg + CNT_W'(1);
            end
            WR_REPARENT: begin
                ram_we    = !np_self;
                ram_waddr = idx_reg;
                ram_wdata = {1'b1, r_ver, np_reg};
            end
            WR_KILL: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = {1'b0, r_ver, r_link};
            end
            WR_CHILD: begin
                ram_we    = 1'b1;
                ram_waddr = rd_addr_reg;
                ram_wdata = {1'b1, r_ver, res_link_reg};
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_comb begin
        res_ok_next   = res_ok_reg;
        res_idx_next  = res_idx_reg;
        res_ver_next  = res_ver_reg;
        res_link_next = res_link_reg;
        if (cmd.res_load) begin
            unique case (cmd.res_sel)
                RES_FAIL_HANDLE: begin
                    res_ok_next   = 1'b0;
                    res_idx_next  = idx_reg;
                    res_ver_next  = ver_reg;
                    res_link_next = '0;
                end
                RES_FAIL_FULL: begin
                    res_ok_next   = 1'b0;
                    res_idx_next  = '0;
                    res_ver_next  = '0;
                    res_link_next = '0;
                end
                RES_REUSE: begin
                    res_ok_next   = 1'b1;
                    res_idx_next  = rd_addr_reg;
                    res_ver_next  = r_ver_inc;
                    res_link_next = np_reg;
                end
                RES_APPEND: begin
                    res_ok_next   = 1'b1;
                    res_idx_next  = used_reg[IDX_W-1:0];
                    res_ver_next  = '0;
                    res_link_next = np_reg;
                end
                RES_LOOKUP, RES_DESTROY: begin
                    res_ok_next   = 1'b1;
                    res_idx_next  = idx_reg;
                    res_ver_next  = ver_reg;
                    res_link_next = r_link;
                end
                RES_REPARENT: begin
                    res_ok_next   = 1'b1;
                    res_idx_next  = idx_reg;
                    res_ver_next  = ver_reg;
                    res_link_next = np_self ? r_link : np_reg;
                end
                default: res_ok_next = 1'b0;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            cnt_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            used_reg    <= used_next;
            cnt_reg     <= cnt_next;
            rd_vld_reg  <= rd_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            op_reg  <= in_opcode;
            idx_reg <= in_slot_index;
            ver_reg <= in_slot_version;
            np_reg  <= in_parent_none ? {1'b1, {(IDX_W + VER_W){1'b0}}}
                                      : {1'b0, in_parent_index, in_parent_version};
        end
        rd_addr_reg  <= rd_addr_next;
        res_ok_reg   <= res_ok_next;
        res_idx_reg  <= res_idx_next;
        res_ver_reg  <= res_ver_next;
        res_link_reg <= res_link_next;
        if (cmd.out_load) begin
            m_ok_reg   <= res_ok_reg;
            m_idx_reg  <= res_idx_reg;
            m_ver_reg  <= res_ver_reg;
            m_link_reg <= res_link_reg;
        end
    end

    assign m_tvalid           = m_valid_reg;
    assign out_success        = m_ok_reg;
    assign out_index          = m_idx_reg;
    assign out_version        = m_ver_reg;
    assign out_parent_none    = m_link_reg[LINK_W-1];
    assign out_parent_index   = m_link_reg[LINK_W-2 -: IDX_W];
    assign out_parent_version = m_link_reg[VER_W-1:0];

endmodule

// ----- hdl/generational_handle_table.sv -----
// Channel | Direction | Beat contents
// s_axis  | in        | tuser: opcode; tdata: handle, parent handle, parent_none
// m_axis  | out       | tdata: success, handle, parent handle, parent_none
//
// Lookup and reparent read the target entry, check it and then pass the result to the output
// register once that is free; only then is the next beat accepted.
// Create and destroy sweep the slot memory one entry per cycle through its single read port:
// create stops at the first dead slot, while a destroy of a valid handle visits every
// slot in use to relink children.
// Reset clears only the slot count and control state; no entry at or above the count is read,
// so there is no clearing pass. A stalled result waits in the output register while the
// next beat is already being worked on; the block holds its last state until it is taken.
module generational_handle_table #(
    parameter int SLOTS        = ght_pkg::SLOTS_DEF,
    parameter int VERSION_BITS = ght_pkg::VERSION_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // From bit 0: slot_index, slot_version, parent_index, parent_version, parent_none, zero pad.
    input  logic [((2 * $clog2(SLOTS) + 2 * VERSION_BITS + 1 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Bit 0 up: opcode.
    input  logic [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // From bit 0: success, out_index, out_version, out_parent_index, out_parent_version,
    // out_parent_none, zero pad.
    output logic [((2 * $clog2(SLOTS) + 2 * VERSION_BITS + 2 + 7) / 8) * 8 - 1:0] m_axis_tdata
);

    import ght_pkg::*;

    localparam int IDX_W   = $clog2(SLOTS);
    localparam int VER_W   = VERSION_BITS;
    localparam int IN_W    = 2 * IDX_W + 2 * VER_W + 1;
    localparam int OUT_W   = 2 * IDX_W + 2 * VER_W + 2;
    localparam int M_DW    = ((OUT_W + 7) / 8) * 8;

    // Offsets of the input fields inside s_axis_tdata.
    localparam int IN_SVER = IDX_W;
    localparam int IN_PIDX = IDX_W + VER_W;
    localparam int IN_PVER = 2 * IDX_W + VER_W;
    localparam int IN_PNON = IN_W - 1;

    cmd_t    cmd;
    status_t status;

    logic               res_success;
    logic [IDX_W-1:0]   res_index;
    logic [VER_W-1:0]   res_version;
    logic [IDX_W-1:0]   res_parent_index;
    logic [VER_W-1:0]   res_parent_version;
    logic               res_parent_none;

    // The sequencer decides which operation step runs each cycle.
    ght_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_opcode (opcode_t'(s_axis_tuser)),
        .s_tready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the slot memory, the slot count, the sweep counter and the
    // result and output registers.
    ght_dp #(
        .SLOTS        (SLOTS),
        .VERSION_BITS (VERSION_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .status             (status),
        .in_opcode          (opcode_t'(s_axis_tuser)),
        .in_slot_index      (s_axis_tdata[IDX_W-1:0]),
        .in_slot_version    (s_axis_tdata[IN_SVER +: VER_W]),
        .in_parent_index    (s_axis_tdata[IN_PIDX +: IDX_W]),
        .in_parent_version  (s_axis_tdata[IN_PVER +: VER_W]),
        .in_parent_none     (s_axis_tdata[IN_PNON]),
        .m_tready           (m_axis_tready),
        .m_tvalid           (m_axis_tvalid),
        .out_success        (res_success),
        .out_index          (res_index),
        .out_version        (res_version),
        .out_parent_index   (res_parent_index),
        .out_parent_version (res_parent_version),
        .out_parent_none    (res_parent_none)
    );

    // Pack the result beat with the first field in the lowest bits.
    assign m_axis_tdata = M_DW'({res_parent_none, res_parent_version, res_parent_index,
                                 res_version, res_index, res_success});

    // Work on one item at a time: an accepted beat always closes the input.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item was in progress");

    // A result only moves to the output register when that register is free.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("pending result would overwrite an untaken output");

    // Appending a slot is never done on a full table.
    a_no_append_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_sel == WR_APPEND |-> !status.full)
        else $error("slot appended to a full table");

    // A target read is followed by its check, during which no new beat is taken.
    a_tgt_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.tgt_rd |=> !s_axis_tready)
        else $error("input opened during target check");

endmodule
